[src/esc_pkg.sv]
// esc_pkg: shared types, register indexes, sequencer codes and shift helpers
// for the environmental sensor compensation block.
// No dependencies; every other file but esc_div refers to it by scoped names.
package esc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // one raw reading set
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } item_t;

    // one compensated result
    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_fixed;
        logic [16:0]        humidity_fixed;
        logic               temperature_valid;
        logic               pressure_valid;
        logic               humidity_valid;
        logic               pressure_divide_zero;
    } result_t;

    // configuration registers
    typedef struct packed {
        logic [47:0]        temp_calibration;
        logic [63:0]        pressure_calibration_a;
        logic [63:0]        pressure_calibration_b;
        logic signed [15:0] pressure_trim_nine;
        logic [63:0]        humidity_calibration;
        logic [2:0]         channel_enable;
    } cfg_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP_CAL,
        REG_PRES_CAL_A,
        REG_PRES_CAL_B,
        REG_PRES_TRIM9,
        REG_HUM_CAL,
        REG_CHAN_EN
    } reg_index_t;

    // channel enable bits
    localparam int EN_TEMP = 0;
    localparam int EN_PRES = 1;
    localparam int EN_HUM  = 2;

    // passes of the shared 32x32 multiplier
    typedef enum logic [1:0] {
        MP_LOW,
        MP_CROSS_A,
        MP_CROSS_B
    } mul_phase_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_GO,
        BK_MUL_WAIT,
        BK_DIV_GO,
        BK_DIV_WAIT,
        BK_OUT
    } bk_state_t;

    // compensation steps, in execution order
    typedef enum logic [4:0] {
        STP_A1,
        STP_DD,
        STP_V2,
        STP_XX,
        STP_Y6,
        STP_Y5,
        STP_W3,
        STP_W2,
        STP_XD,
        STP_NUM,
        STP_DIV,
        STP_E1A,
        STP_E1B,
        STP_E2,
        STP_HA,
        STP_HB1,
        STP_HB2,
        STP_HFB,
        STP_HFB2,
        STP_HV,
        STP_HS,
        STP_HH1
    } step_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [5:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input logic [6:0] s);
        return 64'($signed(v) >>> s);
    endfunction

endpackage

[src/esc_front.sv]
// esc_front: input side; two-entry queue of raw reading sets between the
// push/full port and the back-end sequencer. Depends on esc_pkg.
module esc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  esc_pkg::item_t reading,
    output logic          full,
    output logic          avail,
    output esc_pkg::item_t head,
    input  logic          take
);

    esc_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == 2'd2);
    assign avail   = (count_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = take && avail;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= reading;
    end

endmodule

[src/esc_mul.sv]
// esc_mul: 64x64 multiply keeping the low 64 bits, built from one 32x32
// multiplier over three passes. Depends on esc_pkg.
module esc_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0]         a_reg;
    logic [63:0]         b_reg;
    logic [63:0]         acc_reg;
    esc_pkg::mul_phase_t phase_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [31:0]         opa;
    logic [31:0]         opb;
    logic [63:0]         mp;

    // operand halves for the current pass
    always_comb
    begin
        case (phase_reg)
            esc_pkg::MP_LOW:
            begin
                opa = a_reg[31:0];
                opb = b_reg[31:0];
            end
            esc_pkg::MP_CROSS_A:
            begin
                opa = a_reg[31:0];
                opb = b_reg[63:32];
            end
            default:
            begin
                opa = a_reg[63:32];
                opb = b_reg[31:0];
            end
        endcase
    end

    assign mp   = 64'(opa) * 64'(opb);
    assign done = done_reg;
    assign p    = acc_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esc_pkg::MP_LOW;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            phase_reg <= esc_pkg::MP_LOW;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                esc_pkg::MP_LOW:     phase_reg <= esc_pkg::MP_CROSS_A;
                esc_pkg::MP_CROSS_A: phase_reg <= esc_pkg::MP_CROSS_B;
                default:
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            endcase
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            if (phase_reg == esc_pkg::MP_LOW)
                acc_reg <= mp;
            else
                acc_reg[63:32] <= acc_reg[63:32] + mp[31:0];
        end
    end

endmodule

[src/esc_div.sv]
// esc_div: signed 64-bit division truncating toward zero, one quotient bit
// per cycle (restoring). No dependencies.
module esc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted  = {rem_reg, quo_reg[63]};
    assign diff     = shifted - {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: magnitudes in, shift-subtract, sign fix at the end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[63] ^ divisor[63];
            quo_reg <= dividend[63] ? (64'd0 - dividend) : dividend;
            den_reg <= divisor[63] ? (64'd0 - divisor) : divisor;
            rem_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        else if (fin_reg)
        begin
            if (neg_reg)
                quo_reg <= 64'd0 - quo_reg;
        end
    end

endmodule

[src/esc_back.sv]
// esc_back: back-end sequencer; runs the temperature, pressure and humidity
// polynomials on the shared multiplier and the divider. Depends on esc_pkg,
// esc_mul and esc_div.
module esc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  esc_pkg::cfg_t    cfg,
    input  logic             avail,
    input  esc_pkg::item_t   head,
    output logic             take,
    output logic             res_valid,
    output esc_pkg::result_t res,
    input  logic             res_ready
);

    esc_pkg::bk_state_t state_reg;
    esc_pkg::bk_state_t state_next;
    esc_pkg::step_t     step_reg;
    esc_pkg::step_t     step_next;

    esc_pkg::item_t     item_reg;
    logic [31:0]        v1_reg;
    logic [31:0]        tf_reg;
    logic [31:0]        t32_reg;
    logic [63:0]        x_reg;
    logic [63:0]        xx_reg;
    logic [63:0]        y_reg;
    logic [63:0]        w_reg;
    logic [63:0]        xd_reg;
    logic [63:0]        num_reg;
    logic [63:0]        p_reg;
    logic [63:0]        q_reg;
    logic [63:0]        t64_reg;
    logic [63:0]        e1_reg;
    logic [31:0]        fa_reg;
    logic [31:0]        b1_reg;
    logic [31:0]        fb_reg;
    logic [31:0]        vh_reg;
    logic [15:0]        tc_reg;
    logic [31:0]        pres_reg;
    logic [16:0]        hum_reg;

    logic               mul_start;
    logic               mul_done;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic [63:0]        mp;
    logic               div_start;
    logic               div_done;
    logic [63:0]        div_q;

    // trimming words
    logic [15:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] p6;
    logic [63:0] p7;
    logic [63:0] p8;
    logic [63:0] p9;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
    logic [31:0] h5;
    logic [31:0] h6;

    assign t1 = cfg.temp_calibration[15:0];
    assign t2 = 32'($signed(cfg.temp_calibration[31:16]));
    assign t3 = 32'($signed(cfg.temp_calibration[47:32]));
    assign p1 = 64'(cfg.pressure_calibration_a[15:0]);
    assign p2 = 64'($signed(cfg.pressure_calibration_a[31:16]));
    assign p3 = 64'($signed(cfg.pressure_calibration_a[47:32]));
    assign p4 = 64'($signed(cfg.pressure_calibration_a[63:48]));
    assign p5 = 64'($signed(cfg.pressure_calibration_b[15:0]));
    assign p6 = 64'($signed(cfg.pressure_calibration_b[31:16]));
    assign p7 = 64'($signed(cfg.pressure_calibration_b[47:32]));
    assign p8 = 64'($signed(cfg.pressure_calibration_b[63:48]));
    assign p9 = 64'(cfg.pressure_trim_nine);
    assign h1 = 32'(cfg.humidity_calibration[7:0]);
    assign h2 = 32'($signed(cfg.humidity_calibration[23:8]));
    assign h3 = 32'(cfg.humidity_calibration[31:24]);
    assign h4 = 32'($signed(cfg.humidity_calibration[43:32]));
    assign h5 = 32'($signed(cfg.humidity_calibration[55:44]));
    assign h6 = 32'($signed(cfg.humidity_calibration[63:56]));

    // derived operands
    logic [31:0] a1_op;
    logic [31:0] d_op;
    logic [31:0] hv_op;
    logic [63:0] pn_op;

    function automatic logic [16:0] head_t_hi3();
        return item_reg.raw_temperature[19:3];
    endfunction

    assign a1_op = 32'(head_t_hi3()) - {15'd0, t1, 1'b0};
    assign d_op  = 32'(item_reg.raw_temperature[19:4]) - 32'(t1);
    assign hv_op = tf_reg - 32'd76800;
    assign pn_op = (64'(21'h100000 - 21'(item_reg.raw_pressure)) << 31) - y_reg;

    esc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mp)
    );

    esc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (xd_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // multiplier operands per step
    always_comb
    begin
        case (step_reg)
            esc_pkg::STP_A1:   begin mul_a = 64'(a1_op);            mul_b = 64'(t2);      end
            esc_pkg::STP_DD:   begin mul_a = 64'(d_op);             mul_b = 64'(d_op);    end
            esc_pkg::STP_V2:   begin mul_a = 64'(t32_reg);          mul_b = 64'(t3);      end
            esc_pkg::STP_XX:   begin mul_a = x_reg;                 mul_b = x_reg;        end
            esc_pkg::STP_Y6:   begin mul_a = xx_reg;                mul_b = p6;           end
            esc_pkg::STP_Y5:   begin mul_a = x_reg;                 mul_b = p5;           end
            esc_pkg::STP_W3:   begin mul_a = xx_reg;                mul_b = p3;           end
            esc_pkg::STP_W2:   begin mul_a = x_reg;                 mul_b = p2;           end
            esc_pkg::STP_XD:   begin mul_a = (64'd1 << 47) + w_reg; mul_b = p1;           end
            esc_pkg::STP_NUM:  begin mul_a = pn_op;                 mul_b = 64'd3125;     end
            esc_pkg::STP_E1A:  begin mul_a = p9;                    mul_b = q_reg;        end
            esc_pkg::STP_E1B:  begin mul_a = t64_reg;               mul_b = q_reg;        end
            esc_pkg::STP_E2:   begin mul_a = p8;                    mul_b = p_reg;        end
            esc_pkg::STP_HA:   begin mul_a = 64'(hv_op);            mul_b = 64'(h5);      end
            esc_pkg::STP_HB1:  begin mul_a = 64'(hv_op);            mul_b = 64'(h6);      end
            esc_pkg::STP_HB2:  begin mul_a = 64'(hv_op);            mul_b = 64'(h3);      end
            esc_pkg::STP_HFB:  begin mul_a = 64'(b1_reg);           mul_b = 64'(t32_reg); end
            esc_pkg::STP_HFB2: begin mul_a = 64'(fb_reg);           mul_b = 64'(h2);      end
            esc_pkg::STP_HV:   begin mul_a = 64'(fa_reg);           mul_b = 64'(fb_reg);  end
            esc_pkg::STP_HS:   begin mul_a = 64'(t32_reg);          mul_b = 64'(t32_reg); end
            esc_pkg::STP_HH1:  begin mul_a = 64'(t32_reg);          mul_b = 64'(h1);      end
            default:           begin mul_a = 64'd0;                 mul_b = 64'd0;        end
        endcase
    end

    // post-processing values
    logic [31:0] tf_new;
    logic [31:0] tc_w;
    logic [15:0] tc_sat;
    logic [63:0] pres_w;
    logic [31:0] hum_w;
    logic [16:0] hum_clamped;

    always_comb
    begin
        tf_new = v1_reg + esc_pkg::asr32(mp[31:0], 6'd14);
        tc_w   = esc_pkg::asr32((tf_new << 2) + tf_new + 32'd128, 6'd8);
        if ($signed(tc_w) > 32'sd32767)
            tc_sat = 16'h7FFF;
        else if ($signed(tc_w) < -32'sd32768)
            tc_sat = 16'h8000;
        else
            tc_sat = tc_w[15:0];

        pres_w = esc_pkg::asr64(p_reg + e1_reg + esc_pkg::asr64(mp, 7'd19), 7'd8)
                 + (p7 << 4);

        hum_w = vh_reg - esc_pkg::asr32(mp[31:0], 6'd4);
        if ($signed(hum_w) < 32'sd0)
            hum_clamped = 17'd0;
        else if ($signed(hum_w) > 32'sd419430400)
            hum_clamped = 17'd102400;
        else
            hum_clamped = hum_w[28:12];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        take       = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            esc_pkg::BK_IDLE:
            begin
                if (avail)
                begin
                    take       = 1'b1;
                    step_next  = esc_pkg::STP_A1;
                    state_next = esc_pkg::BK_MUL_GO;
                end
            end
            esc_pkg::BK_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = esc_pkg::BK_MUL_WAIT;
            end
            esc_pkg::BK_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    step_next = esc_pkg::step_t'(5'(step_reg) + 5'd1);
                    if (step_reg == esc_pkg::STP_NUM)
                        state_next = esc_pkg::BK_DIV_GO;
                    else if (step_reg == esc_pkg::STP_HH1)
                        state_next = esc_pkg::BK_OUT;
                    else
                        state_next = esc_pkg::BK_MUL_GO;
                end
            end
            esc_pkg::BK_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = esc_pkg::BK_DIV_WAIT;
            end
            esc_pkg::BK_DIV_WAIT:
            begin
                if (div_done)
                begin
                    step_next  = esc_pkg::STP_E1A;
                    state_next = esc_pkg::BK_MUL_GO;
                end
            end
            esc_pkg::BK_OUT:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = esc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = esc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esc_pkg::BK_IDLE;
            step_reg  <= esc_pkg::STP_A1;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // datapath registers: the item on take, then each product or quotient as it lands
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= head;
        if (state_reg == esc_pkg::BK_DIV_WAIT && div_done)
        begin
            p_reg <= div_q;
            q_reg <= esc_pkg::asr64(div_q, 7'd13);
        end
        if (state_reg == esc_pkg::BK_MUL_WAIT && mul_done)
        begin
            case (step_reg)
                esc_pkg::STP_A1:  v1_reg  <= esc_pkg::asr32(mp[31:0], 6'd11);
                esc_pkg::STP_DD:  t32_reg <= esc_pkg::asr32(mp[31:0], 6'd12);
                esc_pkg::STP_V2:
                begin
                    tf_reg <= tf_new;
                    tc_reg <= tc_sat;
                    x_reg  <= 64'($signed(tf_new)) - 64'd128000;
                end
                esc_pkg::STP_XX:  xx_reg <= mp;
                esc_pkg::STP_Y6:  y_reg  <= mp;
                esc_pkg::STP_Y5:  y_reg  <= y_reg + (mp << 17) + (p4 << 35);
                esc_pkg::STP_W3:  w_reg  <= esc_pkg::asr64(mp, 7'd8);
                esc_pkg::STP_W2:  w_reg  <= w_reg + (mp << 12);
                esc_pkg::STP_XD:  xd_reg <= esc_pkg::asr64(mp, 7'd33);
                esc_pkg::STP_NUM: num_reg <= mp;
                esc_pkg::STP_E1A: t64_reg <= mp;
                esc_pkg::STP_E1B: e1_reg  <= esc_pkg::asr64(mp, 7'd25);
                esc_pkg::STP_E2:  pres_reg <= pres_w[31:0];
                esc_pkg::STP_HA:
                    fa_reg <= esc_pkg::asr32((32'(item_reg.raw_humidity) << 14) - (h4 << 20)
                                             - mp[31:0] + 32'd16384, 6'd15);
                esc_pkg::STP_HB1: b1_reg  <= esc_pkg::asr32(mp[31:0], 6'd10);
                esc_pkg::STP_HB2: t32_reg <= esc_pkg::asr32(mp[31:0], 6'd11) + 32'd32768;
                esc_pkg::STP_HFB: fb_reg  <= esc_pkg::asr32(mp[31:0], 6'd10) + 32'd2097152;
                esc_pkg::STP_HFB2:
                    fb_reg <= esc_pkg::asr32(mp[31:0] + 32'd8192, 6'd14);
                esc_pkg::STP_HV:
                begin
                    vh_reg  <= mp[31:0];
                    t32_reg <= esc_pkg::asr32(mp[31:0], 6'd15);
                end
                esc_pkg::STP_HS:  t32_reg <= esc_pkg::asr32(mp[31:0], 6'd7);
                esc_pkg::STP_HH1: hum_reg <= hum_clamped;
                default:          t64_reg <= t64_reg;
            endcase
        end
    end

    // result assembly; disabled channels read as zero
    logic en_t;
    logic en_p;
    logic en_h;
    logic xd_zero;

    assign en_t    = cfg.channel_enable[esc_pkg::EN_TEMP];
    assign en_p    = cfg.channel_enable[esc_pkg::EN_PRES];
    assign en_h    = cfg.channel_enable[esc_pkg::EN_HUM];
    assign xd_zero = (xd_reg == 64'd0);

    always_comb
    begin
        res.temperature_centi    = en_t ? tc_reg : 16'd0;
        res.pressure_fixed       = (en_p && !xd_zero) ? pres_reg : 32'd0;
        res.humidity_fixed       = en_h ? hum_reg : 17'd0;
        res.temperature_valid    = en_t;
        res.pressure_valid       = en_p;
        res.humidity_valid       = en_h;
        res.pressure_divide_zero = en_p && xd_zero;
    end

endmodule

[src/environmental_sensor_compensation_top.sv]
// environmental_sensor_compensation_top: configuration registers, front queue,
// back-end sequencer and the result register. Depends on esc_pkg, esc_front,
// esc_back.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+------------------
//   reading   | in        | push / full            | esc_pkg::item_t
//   result    | out       | pop / empty            | esc_pkg::result_t
//   config    | in        | cfg_write (no wait)    | cfg_index, cfg_data
//
// Each reading set passes through the back end from take to result as 21 products
// on one 32x32 multiplier and a bit-serial 64-bit divide. The front queue holds
// two requests while the back end works.
// Reset (rst_n low, asynchronous) clears the queues and the configuration.
// The back end stalls only when the result register is full and pop is low.
module environmental_sensor_compensation_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  esc_pkg::item_t                  reading,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output esc_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    esc_pkg::cfg_t    cfg_reg;
    esc_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             avail;
    esc_pkg::item_t   head;
    logic             take;
    logic             res_valid;
    esc_pkg::result_t res;
    logic             res_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (esc_pkg::reg_index_t'(cfg_index))
                esc_pkg::REG_TEMP_CAL:   cfg_reg.temp_calibration       <= cfg_data[47:0];
                esc_pkg::REG_PRES_CAL_A: cfg_reg.pressure_calibration_a <= cfg_data;
                esc_pkg::REG_PRES_CAL_B: cfg_reg.pressure_calibration_b <= cfg_data;
                esc_pkg::REG_PRES_TRIM9: cfg_reg.pressure_trim_nine     <= cfg_data[15:0];
                esc_pkg::REG_HUM_CAL:    cfg_reg.humidity_calibration   <= cfg_data;
                esc_pkg::REG_CHAN_EN:    cfg_reg.channel_enable         <= cfg_data[2:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    esc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .reading (reading),
        .full    (full),
        .avail   (avail),
        .head    (head),
        .take    (take)
    );

    esc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .avail     (avail),
        .head      (head),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // result register
    assign res_ready = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

endmodule

[dv/tb.sv]
// tb: self-checking bench for environmental_sensor_compensation_top.
// Depends on esc_pkg and the top level; drives readings, calibration writes
// and result pops, and checks every result against a bit-exact predictor or a directed value.
`timescale 1ns / 1ps

module tb;

    localparam logic [esc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 200;
    localparam int BLOCK_ITEMS  = 60;

    // typical factory trims
    localparam logic [63:0] TYP_TEMP  = 64'h0000_FC18_6743_6B70;
    localparam logic [63:0] TYP_PRESA = 64'h0B27_0BD0_D643_8E7D;
    localparam logic [63:0] TYP_PRESB = 64'hC6F8_3C8C_FFF9_008C;
    localparam logic [63:0] TYP_TRIM9 = 64'h0000_0000_0000_1770;
    localparam logic [63:0] TYP_HUM   = 64'h1E03_2144_0001_6A4B;

    typedef logic [63:0] setting_t [6];

    typedef struct {
        int               setting;
        esc_pkg::item_t   rd;
        bit               typed;
        esc_pkg::result_t want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    esc_pkg::item_t   reading = '0;
    logic             full;
    logic             empty;
    logic             pop = 1'b0;
    esc_pkg::result_t result;
    logic             cfg_write = 1'b0;
    logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the calibration registers
    logic [47:0] cal_temp;
    logic [63:0] cal_pres_a;
    logic [63:0] cal_pres_b;
    logic [15:0] cal_trim9;
    logic [63:0] cal_hum;
    logic [2:0]  chan_en;

    esc_pkg::result_t pending_results[$];
    int      fails = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;
    int      pop_stall = 0;
    setting_t settings [6];
    stim_row_t rows [$];
    int      cur_setting = 0;

    environmental_sensor_compensation_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .reading   (reading),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sar_w(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [63:0] sar_d(input logic [63:0] v, input int n);
        return 64'($signed(v) >>> n);
    endfunction

    // signed 64-bit divide, truncating toward zero, wrapping on overflow
    function automatic logic [63:0] sdiv_d(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q  = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic void apply_reg(input logic [esc_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [63:0] data);
        case (idx)
            esc_pkg::REG_TEMP_CAL:   cal_temp   = data[47:0];
            esc_pkg::REG_PRES_CAL_A: cal_pres_a = data;
            esc_pkg::REG_PRES_CAL_B: cal_pres_b = data;
            esc_pkg::REG_PRES_TRIM9: cal_trim9  = data[15:0];
            esc_pkg::REG_HUM_CAL:    cal_hum    = data;
            esc_pkg::REG_CHAN_EN:    chan_en    = data[2:0];
            default: ;
        endcase
    endfunction

    // compensated result for one reading set under the current trims
    function automatic esc_pkg::result_t compensate(input esc_pkg::item_t rd);
        esc_pkg::result_t r;
        logic [31:0] at, ah, t1, t2, t3, d, tf, tc, v, fa, b1, b2, fb, s;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [63:0] x, y, p, q, e1, e2;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        r = '0;
        at = 32'(rd.raw_temperature);
        ah = 32'(rd.raw_humidity);

        // fine temperature, always from this set's raw temperature
        t1 = {16'b0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        d  = (at >> 4) - t1;
        tf = sar_w(((at >> 3) - (t1 << 1)) * t2, 11)
           + sar_w(sar_w(d * d, 12) * t3, 14);

        // temperature, saturated to 16 bits
        tc = sar_w(tf * 32'd5 + 32'd128, 8);
        if ($signed(tc) > 32767)
            tc = 32'd32767;
        if ($signed(tc) < -32768)
            tc = -32'd32768;
        if (chan_en[esc_pkg::EN_TEMP])
        begin
            r.temperature_centi = tc[15:0];
            r.temperature_valid = 1'b1;
        end

        // pressure
        p1 = {48'b0, cal_pres_a[15:0]};
        p2 = {{48{cal_pres_a[31]}}, cal_pres_a[31:16]};
        p3 = {{48{cal_pres_a[47]}}, cal_pres_a[47:32]};
        p4 = {{48{cal_pres_a[63]}}, cal_pres_a[63:48]};
        p5 = {{48{cal_pres_b[15]}}, cal_pres_b[15:0]};
        p6 = {{48{cal_pres_b[31]}}, cal_pres_b[31:16]};
        p7 = {{48{cal_pres_b[47]}}, cal_pres_b[47:32]};
        p8 = {{48{cal_pres_b[63]}}, cal_pres_b[63:48]};
        p9 = {{48{cal_trim9[15]}}, cal_trim9};
        x = {{32{tf[31]}}, tf} - 64'd128000;
        y = x * x * p6;
        y = y + ((x * p5) << 17);
        y = y + (p4 << 35);
        x = sar_d(x * x * p3, 8) + ((x * p2) << 12);
        x = sar_d(((64'd1 << 47) + x) * p1, 33);
        if (chan_en[esc_pkg::EN_PRES])
        begin
            r.pressure_valid = 1'b1;
            if (x == 64'd0)
                r.pressure_divide_zero = 1'b1;
            else
            begin
                p  = 64'd1048576 - {44'b0, rd.raw_pressure};
                p  = sdiv_d(((p << 31) - y) * 64'd3125, x);
                q  = sar_d(p, 13);
                e1 = sar_d(p9 * q * q, 25);
                e2 = sar_d(p8 * p, 19);
                p  = sar_d(p + e1 + e2, 8) + (p7 << 4);
                r.pressure_fixed = p[31:0];
            end
        end

        // humidity, clamped to 0..100 %
        h1 = {24'b0, cal_hum[7:0]};
        h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
        h3 = {24'b0, cal_hum[31:24]};
        h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
        h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
        h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
        v  = tf - 32'd76800;
        fa = sar_w((ah << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        b1 = sar_w(v * h6, 10);
        b2 = sar_w(v * h3, 11) + 32'd32768;
        fb = sar_w(b1 * b2, 10) + 32'd2097152;
        fb = sar_w(fb * h2 + 32'd8192, 14);
        v  = fa * fb;
        s  = sar_w(v, 15);
        v  = v - sar_w(sar_w(s * s, 7) * h1, 4);
        if ($signed(v) < 0)
            v = 32'd0;
        if ($signed(v) > 419430400)
            v = 32'd419430400;
        if (chan_en[esc_pkg::EN_HUM])
        begin
            r.humidity_fixed = v[28:12];
            r.humidity_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // result side: compare each popped result, random stall bursts
    always @(posedge clk)
    begin
        esc_pkg::result_t want;
        if (pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result popped with no request outstanding");
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("temperature_centi", $signed(want.temperature_centi),
                            $signed(result.temperature_centi));
                check_field("pressure_fixed", want.pressure_fixed, result.pressure_fixed);
                check_field("humidity_fixed", want.humidity_fixed, result.humidity_fixed);
                check_field("temperature_valid", want.temperature_valid,
                            result.temperature_valid);
                check_field("pressure_valid", want.pressure_valid, result.pressure_valid);
                check_field("humidity_valid", want.humidity_valid, result.humidity_valid);
                check_field("pressure_divide_zero", want.pressure_divide_zero,
                            result.pressure_divide_zero);
            end
        end
        if (!rst_n || calm)
            pop <= 1'b1;
        else if (pop_stall > 0)
        begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            pop_stall <= $urandom_range(0, 16);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // write all registers plus an unused index; model updates at each edge
    task automatic program_regs(input setting_t sv);
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= esc_pkg::CFG_INDEX_W'(i);
            cfg_data  <= sv[i];
            @(posedge clk);
            apply_reg(esc_pkg::CFG_INDEX_W'(i), sv[i]);
        end
        cfg_write <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // hold the sender until every outstanding request has its result
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one request; the caller lowers push or offers the next one
    task automatic send(input esc_pkg::item_t rd, input bit typed,
                        input esc_pkg::result_t want);
        push    <= 1'b1;
        reading <= rd;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(typed ? want : compensate(rd));
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic esc_pkg::item_t random_reading(input bit typical);
        esc_pkg::item_t rd;
        rd.raw_temperature = 20'($urandom);
        rd.raw_pressure    = 20'($urandom);
        rd.raw_humidity    = 16'($urandom);
        if (typical)
        begin
            rd.raw_temperature = 20'($urandom_range(420000, 620000));
            rd.raw_pressure    = 20'($urandom_range(250000, 520000));
            rd.raw_humidity    = 16'($urandom_range(15000, 45000));
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            rd.raw_temperature = $urandom_range(0, 1) ? '1 : '0;
            rd.raw_pressure    = $urandom_range(0, 1) ? '1 : '0;
            rd.raw_humidity    = $urandom_range(0, 1) ? '1 : '0;
        end
        return rd;
    endfunction

    function automatic void add_row(input int setting, input esc_pkg::item_t rd,
                                    input bit typed, input esc_pkg::result_t want);
        stim_row_t row;
        row.setting = setting;
        row.rd      = rd;
        row.typed   = typed;
        row.want    = want;
        rows.push_back(row);
    endfunction

    initial
    begin
        setting_t sv;
        esc_pkg::result_t zero_res;
        esc_pkg::result_t dz_res;
        esc_pkg::item_t lo_rd;
        esc_pkg::item_t hi_rd;
        esc_pkg::item_t typ_rd;
        esc_pkg::item_t mix_rd;

        // settings: reset values, enables only, typical trims, pressure only,
        // all ones, typical with extreme pressure corrections
        settings[0] = '{default: 64'd0};
        settings[1] = '{0, 0, 0, 0, 0, 64'd7};
        settings[2] = '{TYP_TEMP, TYP_PRESA, TYP_PRESB, TYP_TRIM9, TYP_HUM, 64'd7};
        settings[3] = '{TYP_TEMP, TYP_PRESA, TYP_PRESB, TYP_TRIM9, TYP_HUM,
                        64'hFFFF_FFFF_FFFF_FFFA};
        settings[4] = '{default: '1};
        settings[5] = '{TYP_TEMP, TYP_PRESA, 64'h8000_7FFF_8000_7FFF,
                        64'hFFFF_FFFF_FFFF_8000, TYP_HUM, 64'd7};

        zero_res = '0;
        dz_res = '0;
        dz_res.temperature_valid = 1'b1;
        dz_res.pressure_valid = 1'b1;
        dz_res.humidity_valid = 1'b1;
        dz_res.pressure_divide_zero = 1'b1;
        lo_rd  = '0;
        hi_rd  = '1;
        typ_rd = '{20'd519888, 20'd415148, 16'd28000};
        mix_rd = '{20'hFFFFF, 20'h00000, 16'hFFFF};

        // directed table: reset state, zero divisor, typical and extreme trims
        add_row(0, lo_rd, 1, zero_res);
        add_row(0, hi_rd, 1, zero_res);
        add_row(0, typ_rd, 1, zero_res);
        add_row(1, lo_rd, 1, dz_res);
        add_row(1, hi_rd, 1, dz_res);
        add_row(1, typ_rd, 1, dz_res);
        add_row(2, typ_rd, 0, zero_res);
        add_row(2, lo_rd, 0, zero_res);
        add_row(2, hi_rd, 0, zero_res);
        add_row(2, mix_rd, 0, zero_res);
        add_row(2, '{20'd519888, 20'hFFFFF, 16'd0}, 0, zero_res);
        add_row(2, '{20'd300000, 20'd1, 16'd65535}, 0, zero_res);
        add_row(3, typ_rd, 0, zero_res);
        add_row(3, hi_rd, 0, zero_res);
        add_row(4, lo_rd, 0, zero_res);
        add_row(4, hi_rd, 0, zero_res);
        add_row(4, typ_rd, 0, zero_res);
        add_row(5, typ_rd, 0, zero_res);
        add_row(5, lo_rd, 0, zero_res);
        add_row(5, hi_rd, 0, zero_res);

        apply_reg(esc_pkg::REG_TEMP_CAL, 0);
        apply_reg(esc_pkg::REG_PRES_CAL_A, 0);
        apply_reg(esc_pkg::REG_PRES_CAL_B, 0);
        apply_reg(esc_pkg::REG_PRES_TRIM9, 0);
        apply_reg(esc_pkg::REG_HUM_CAL, 0);
        apply_reg(esc_pkg::REG_CHAN_EN, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].setting != cur_setting)
            begin
                drain();
                cur_setting = rows[i].setting;
                program_regs(settings[cur_setting]);
            end
            send(rows[i].rd, rows[i].typed, rows[i].want);
        end

        // random blocks, each under its own trims
        for (int b = 0; b < 8; b++)
        begin
            drain();
            case (b)
                0: sv = settings[2];
                1: sv = settings[4];
                2: sv = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
                3: sv = '{TYP_TEMP, TYP_PRESA, TYP_PRESB, TYP_TRIM9, TYP_HUM,
                          64'($urandom_range(0, 7))};
                4: sv = settings[1];
                5: sv = '{TYP_TEMP ^ 64'($urandom_range(0, 255)),
                          {TYP_PRESA[63:16], 16'($urandom)}, {$urandom, $urandom},
                          64'($urandom), {$urandom, $urandom}, 64'd7};
                6: sv = settings[5];
                default:
                begin
                    sv = settings[2];
                    calm = 1'b1;
                end
            endcase
            program_regs(sv);
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send(random_reading($urandom_range(0, 3) != 0), 0, zero_res);
        end

        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
